@@ hw/rtl/line_ending_translator_defines.svh @@
// assertion macros for the line ending translator checker
// depends on nothing; included by the checker file
`ifndef LINE_ENDING_TRANSLATOR_DEFINES_SVH
`define LINE_ENDING_TRANSLATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LET_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LET_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/let_pkg.sv @@
// shared types and constants of the line ending translator
// no dependencies; imported by line_ending_translator, let_front, let_queue and let_back
package let_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [2:0] MODE_NONE       = 3'd0;
   localparam logic [2:0] MODE_CR_TO_CRLF = 3'd1;
   localparam logic [2:0] MODE_LF_TO_CRLF = 3'd2;
   localparam logic [2:0] MODE_CRLF_TO_CR = 3'd3;
   localparam logic [2:0] MODE_LF_TO_CR   = 3'd4;
   localparam logic [2:0] MODE_CRLF_TO_LF = 3'd5;
   localparam logic [2:0] MODE_CR_TO_LF   = 3'd6;

   localparam int QUEUE_DEPTH_DEF = 4;

   // one translated input: one or two output bytes
   typedef struct packed {
      logic       two;
      logic [7:0] b0;
      logic [7:0] b1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

@@ hw/rtl/line_ending_translator.sv @@
// line ending translator: one byte in, zero to two bytes out per item
// an accepted item passes through the queue and then the output register to the result ports
// throughput: one item per cycle while req_full is low; an item that expands to two bytes
// holds the output register for both of its bytes, the queue absorbs the difference
// reset (synchronous, active high) sets mode to pass-through, clears seen-cr and
// empties queue and output register; depends on let_pkg, let_front, let_queue, let_back
module line_ending_translator
   import let_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_mode
);

   push_type  push;
   entry_type q_head;
   logic      q_empty, q_full, q_pop;

   assign req_full = q_full;

   let_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_push && !q_full),
      .in_byte   (req_in_byte),
      .csr_wr_en (csr_wr_en),
      .csr_mode  (csr_mode),
      .push      (push)
   );

   let_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .empty (q_empty),
      .full  (q_full),
      .head  (q_head)
   );

   let_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

@@ hw/rtl/let_front.sv @@
// front end: mode register, seen-cr flag and per-item classification
// depends on let_pkg; feeds let_queue
module let_front
   import let_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_mode,
   output push_type   push
);

   logic [2:0] mode_ff, mode_in;
   logic       seen_cr_ff, seen_cr_in;
   logic       emit;
   logic       two;
   logic [7:0] b0, b1;
   logic       next_seen;

   always_comb begin
      emit      = 1'b1;
      two       = 1'b0;
      b0        = in_byte;
      b1        = in_byte;
      next_seen = seen_cr_ff;
      unique case (mode_ff)
         MODE_CR_TO_CRLF: begin
            if (in_byte == CH_CR) begin
               two = 1'b1;
               b0  = CH_CR;
               b1  = CH_LF;
            end
         end
         MODE_LF_TO_CRLF: begin
            if (in_byte == CH_LF) begin
               two = 1'b1;
               b0  = CH_CR;
               b1  = CH_LF;
            end
         end
         MODE_CRLF_TO_CR: begin
            if (seen_cr_ff) begin
               next_seen = 1'b0;
               emit      = (in_byte != CH_LF);
            end else begin
               next_seen = (in_byte == CH_CR);
            end
         end
         MODE_LF_TO_CR: begin
            if (in_byte == CH_LF) begin
               b0 = CH_CR;
            end
         end
         MODE_CRLF_TO_LF: begin
            if (seen_cr_ff) begin
               next_seen = 1'b0;
               if (in_byte != CH_LF) begin
                  two = 1'b1;
                  b0  = CH_CR;
               end
            end else if (in_byte == CH_CR) begin
               next_seen = 1'b1;
               emit      = 1'b0;
            end
         end
         MODE_CR_TO_LF: begin
            if (in_byte == CH_CR) begin
               b0 = CH_LF;
            end
         end
         default: begin
            emit = 1'b1;
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      seen_cr_in = seen_cr_ff;
      priority if (csr_wr_en) begin
         mode_in    = csr_mode;
         seen_cr_in = 1'b0;
      end else if (accept) begin
         seen_cr_in = next_seen;
      end else begin
         seen_cr_in = seen_cr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NONE;
         seen_cr_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         seen_cr_ff <= seen_cr_in;
      end
   end

   assign push.valid     = accept && emit;
   assign push.entry.two = two;
   assign push.entry.b0  = b0;
   assign push.entry.b1  = b1;

endmodule

@@ hw/rtl/let_queue.sv @@
// short queue of translated entries between front and back
// depends on let_pkg
module let_queue
   import let_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output logic      empty,
   output logic      full,
   output entry_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   entry_type     mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

@@ hw/rtl/let_back.sv @@
// back end: output register that plays out one or two bytes per entry
// depends on let_pkg; drains let_queue
module let_back
   import let_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  entry_type  q_head,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic      valid_ff, valid_in;
   logic      phase_ff, phase_in;
   entry_type cur_ff, cur_in;
   logic      take, second, load;

   assign take   = valid_ff && rsp_pop;
   assign second = take && cur_ff.two && !phase_ff;
   assign load   = !valid_ff || (take && !second);
   assign q_pop  = load && !q_empty;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      priority if (second) begin
         phase_in = 1'b1;
      end else if (load) begin
         valid_in = !q_empty;
         phase_in = 1'b0;
         cur_in   = q_head;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = phase_ff ? cur_ff.b1 : cur_ff.b0;
   assign rsp_last     = phase_ff || !cur_ff.two;

endmodule

@@ hw/rtl/let_checker.sv @@
// port-level checker of the line ending translator, bound to the top level
// depends on line_ending_translator_defines.svh
`include "line_ending_translator_defines.svh"

module let_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   `LET_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_out_byte) && $stable(rsp_last),
      "result item changed while stalled")
   `LET_ASSERT_NEXT(a_second_byte, !rsp_empty && rsp_pop && !rsp_last, !rsp_empty,
      "second byte of a pair missing")
   `LET_ASSERT_NOW(a_full_not_empty, req_full, !rsp_empty, "queue full while output empty")

endmodule

bind line_ending_translator let_checker u_let_checker (.*);

@@ tb/testbench.sv @@
// testbench for line_ending_translator: a directed table, then random byte streams
// in all eight mode values under four idle/stall mixes, checked against a predictor
// depends on let_pkg and the line_ending_translator rtl
module testbench;
   import let_pkg::*;

   localparam logic [2:0] MODE_SPARE = 3'd7;
   localparam int DRAIN_CYCLES = 8;
   localparam int SEGMENT_ITEMS = 55;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       known;
      logic [1:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
   } send_item_type;

   typedef struct packed {
      logic          set_mode;
      logic [2:0]    mode;
      send_item_type item;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } out_item_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic [2:0] csr_mode = MODE_NONE;

   send_item_type bytes_to_send[$];
   out_item_type  out_bytes_due[$];

   logic [2:0] xlate_mode = MODE_NONE;
   logic       cr_held = 1'b0;

   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   line_ending_translator DUT (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_mode     (csr_mode)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int translate_byte(input logic [7:0] b, output logic [7:0] first,
                                         output logic [7:0] second);
      int n;
      n = 1;
      first = b;
      second = 8'h00;
      case (xlate_mode)
         MODE_CR_TO_CRLF: if (b == CH_CR) begin
            first = CH_CR;
            second = CH_LF;
            n = 2;
         end
         MODE_LF_TO_CRLF: if (b == CH_LF) begin
            first = CH_CR;
            second = CH_LF;
            n = 2;
         end
         MODE_CRLF_TO_CR: if (cr_held) begin
            cr_held = 1'b0;
            if (b == CH_LF) n = 0;
         end else if (b == CH_CR) begin
            cr_held = 1'b1;
         end
         MODE_LF_TO_CR: if (b == CH_LF) first = CH_CR;
         MODE_CRLF_TO_LF: if (cr_held) begin
            cr_held = 1'b0;
            if (b != CH_LF) begin
               first = CH_CR;
               second = b;
               n = 2;
            end
         end else if (b == CH_CR) begin
            cr_held = 1'b1;
            n = 0;
         end
         MODE_CR_TO_LF: if (b == CH_CR) first = CH_LF;
         default: ;
      endcase
      return n;
   endfunction

   function automatic stim_row_type stim_row(input logic set_mode, input logic [2:0] mode,
                                             input logic [7:0] b, input logic known,
                                             input logic [1:0] count, input logic [7:0] b0,
                                             input logic [7:0] b1);
      stim_row = {set_mode, mode, b, known, count, b0, b1};
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      bytes_to_send.push_back({b, 1'b0, 2'd0, 8'h00, 8'h00});
   endtask

   task automatic wait_drained();
      while (bytes_to_send.size() != 0 || out_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [2:0] m);
      wait_drained();
      csr_mode <= m;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      xlate_mode = m;
      cr_held = 1'b0;
   endtask

   always @(posedge clock) begin : sender
      send_item_type head;
      logic [7:0]    p0, p1;
      int            pn;
      logic          idle;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            head = bytes_to_send.pop_front();
            pn = translate_byte(head.in_byte, p0, p1);
            if (head.known) begin
               pn = int'(head.count);
               p0 = head.b0;
               p1 = head.b1;
            end
            if (pn == 1) begin
               out_bytes_due.push_back({p0, 1'b1});
            end else if (pn == 2) begin
               out_bytes_due.push_back({p0, 1'b0});
               out_bytes_due.push_back({p1, 1'b1});
            end
         end
         idle = ($urandom_range(0, 99) < send_idle_pct);
         // an item refused by full stays on the port
         if (!(req_push && req_full)) begin
            if (bytes_to_send.size() != 0 && !idle) begin
               req_push <= 1'b1;
               req_in_byte <= bytes_to_send[0].in_byte;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      out_item_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (out_bytes_due.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected item: byte %02h last %0d", rsp_out_byte, rsp_last);
            end else begin
               want = out_bytes_due.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_last !== want.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                              want.out_byte, want.last, rsp_out_byte, rsp_last);
               end
            end
         end
         rsp_pop <= !($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin : sequencer
      stim_row_type dir_table[$];
      logic [2:0]   seg_mode;
      int           phase, seg, count, pick;

      // after reset: pass-through
      dir_table.push_back(stim_row(0, MODE_NONE, 8'h00, 1, 1, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_NONE, 8'hFF, 1, 1, 8'hFF, 8'h00));
      dir_table.push_back(stim_row(0, MODE_NONE, CH_CR, 1, 1, CH_CR, 8'h00));
      dir_table.push_back(stim_row(1, MODE_CR_TO_CRLF, CH_CR, 1, 2, CH_CR, CH_LF));
      dir_table.push_back(stim_row(0, MODE_CR_TO_CRLF, CH_LF, 1, 1, CH_LF, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CR_TO_CRLF, 8'h41, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(1, MODE_LF_TO_CRLF, CH_LF, 1, 2, CH_CR, CH_LF));
      dir_table.push_back(stim_row(0, MODE_LF_TO_CRLF, CH_CR, 1, 1, CH_CR, 8'h00));
      // cr lf collapse, then a repeated cr that does not re-arm
      dir_table.push_back(stim_row(1, MODE_CRLF_TO_CR, CH_CR, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_CR, CH_LF, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_CR, CH_CR, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_CR, CH_CR, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_CR, CH_LF, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(1, MODE_LF_TO_CR, CH_LF, 1, 1, CH_CR, 8'h00));
      dir_table.push_back(stim_row(0, MODE_LF_TO_CR, 8'hFF, 1, 1, 8'hFF, 8'h00));
      // held cr, released by lf, by another byte and by another cr
      dir_table.push_back(stim_row(1, MODE_CRLF_TO_LF, CH_CR, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_LF, CH_LF, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_LF, CH_CR, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_LF, 8'h41, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_LF, CH_CR, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_LF, CH_CR, 0, 0, 8'h00, 8'h00));
      // a mode write drops the held cr
      dir_table.push_back(stim_row(0, MODE_CRLF_TO_LF, CH_CR, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(1, MODE_CRLF_TO_LF, 8'h41, 0, 0, 8'h00, 8'h00));
      dir_table.push_back(stim_row(1, MODE_CR_TO_LF, CH_CR, 1, 1, CH_LF, 8'h00));
      dir_table.push_back(stim_row(0, MODE_CR_TO_LF, CH_LF, 1, 1, CH_LF, 8'h00));
      dir_table.push_back(stim_row(1, MODE_SPARE, CH_CR, 1, 1, CH_CR, 8'h00));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         if (dir_table[i].set_mode) write_mode(dir_table[i].mode);
         bytes_to_send.push_back(dir_table[i].item);
      end

      for (phase = 0; phase < 4; phase++) begin
         for (seg = 0; seg < 8; seg++) begin
            seg_mode = 3'((seg + phase) % 8);
            write_mode(seg_mode);
            case (phase)
               0: begin
                  send_idle_pct = 0;
                  recv_stall_pct = 0;
               end
               1: begin
                  send_idle_pct = 82;
                  recv_stall_pct = 0;
               end
               2: begin
                  send_idle_pct = 0;
                  recv_stall_pct = 82;
               end
               default: begin
                  send_idle_pct = 34;
                  recv_stall_pct = 34;
               end
            endcase
            count = 0;
            while (count < SEGMENT_ITEMS) begin
               pick = $urandom_range(0, 99);
               if (pick < 30) begin
                  queue_byte(CH_CR);
                  queue_byte(CH_LF);
                  count += 2;
               end else if (pick < 45) begin
                  queue_byte(CH_CR);
                  count += 1;
               end else if (pick < 60) begin
                  queue_byte(CH_LF);
                  count += 1;
               end else if (pick < 70) begin
                  queue_byte(CH_CR);
                  queue_byte(CH_CR);
                  queue_byte(CH_LF);
                  count += 3;
               end else begin
                  queue_byte(8'($urandom_range(0, 255)));
                  count += 1;
               end
            end
         end
      end

      wait_drained();
      if (out_bytes_due.size() != 0) errors++;
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
